/* hw/rtl/terp_pkg.sv */
// Shared widths, codes and control types of the timed easing ramp.
package terp_pkg;

  localparam int unsigned PHASE_FRAC_BITS = 16;
  localparam int unsigned TIME_BITS       = 64;

  localparam int unsigned PINT_BITS  = 8;
  localparam int unsigned PW         = PINT_BITS + PHASE_FRAC_BITS;
  localparam int unsigned VW         = 32;
  localparam int unsigned CW         = PW + PINT_BITS;
  localparam int unsigned FPAD       = PHASE_FRAC_BITS + PHASE_FRAC_BITS % 2;
  localparam int unsigned CPW        = 2 * PINT_BITS + FPAD;
  localparam int unsigned NDIG       = CPW / 2;
  localparam int unsigned CI_DIGITS  = PINT_BITS;
  localparam int unsigned ACW        = CPW + VW;
  localparam int unsigned TW         = ACW - FPAD;
  localparam int unsigned RW         = TW + 2;
  localparam int unsigned DVW        = TIME_BITS + PINT_BITS;
  localparam int unsigned DCNTW      = $clog2(PW + 1);
  localparam int unsigned MCNTW      = $clog2(NDIG);
  localparam int unsigned OVF_EXP    = 40;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned NOW_W      = 64;
  localparam int unsigned DUR_W      = 40;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK       = 2'd0,
    MODE_ACTIVATE   = 2'd1,
    MODE_DEACTIVATE = 2'd2
  } terp_mode_e;

  typedef enum logic [SEL_W-1:0] {
    CM_NORMAL      = 3'd0,
    CM_CLAMP       = 3'd1,
    CM_CLAMP_START = 3'd2,
    CM_WRAP        = 3'd3,
    CM_LOOP_ONCE   = 3'd4,
    CM_LOOP        = 3'd5
  } terp_count_e;

  typedef enum logic [SEL_W-1:0] {
    CV_NONE       = 3'd0,
    CV_LINEAR     = 3'd1,
    CV_SQUARE     = 3'd2,
    CV_INV_SQUARE = 3'd3,
    CV_SPLIT      = 3'd4
  } terp_curve_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_MODE   = 4'd0,
    REG_CURVE_SELECT = 4'd1,
    REG_RANGE_START  = 4'd2,
    REG_RANGE_END    = 4'd3
  } terp_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CURVE,
    S_SQR,
    S_MUL,
    S_SUM,
    S_FIN
  } terp_state_e;

  typedef struct packed {
    logic load;
    logic run;
  } terp_unit_ctl_t;

  typedef struct packed {
    logic          done;
    logic          sat;
    logic [PW-1:0] quo;
  } terp_div_sts_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } terp_mul_sts_t;

endpackage

/* hw/rtl/terp_if.sv */
// Request channels of the timed easing ramp: input items and result items.
interface terp_in_if;
  import terp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NOW_W-1:0]  now_us;
  logic [DUR_W-1:0]  duration_us;

  modport source (output valid, mode, now_us, duration_us, input ready);
  modport sink   (input valid, mode, now_us, duration_us, output ready);
endinterface

interface terp_out_if;
  import terp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] value;
  logic                 active;
  logic                 saturated;

  modport source (output valid, value, active, saturated, input ready);
  modport sink   (input valid, value, active, saturated, output ready);
endinterface

/* hw/rtl/terp_div.sv */
// Radix-2 phase divider: one quotient bit per cycle into a shift register.
module terp_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  terp_pkg::terp_unit_ctl_t         ctl_i,
  input  logic [terp_pkg::TIME_BITS-1:0]   el_i,
  input  logic [terp_pkg::TIME_BITS-1:0]   tot_i,
  output terp_pkg::terp_div_sts_t          sts_o
);
  import terp_pkg::*;

  logic [TIME_BITS:0]   r_q;
  logic [DVW-1:0]       d_q;
  logic [PW-1:0]        q_q;
  logic                 sat_q;
  logic [DCNTW-1:0]     cnt_q;

  logic [TIME_BITS:0]   opnd;
  logic [DVW-1:0]       opnd_ext;
  logic [DVW-1:0]       sub;
  logic                 ge;

  // integer steps use the shifted divisor, fraction steps shift the remainder
  always_comb begin
    opnd     = (cnt_q > DCNTW'(PINT_BITS)) ? {r_q[TIME_BITS-1:0], 1'b0} : r_q;
    opnd_ext = DVW'(opnd);
    ge       = opnd_ext >= d_q;
    sub      = opnd_ext - d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.load) begin
      cnt_q <= '0;
    end else if (ctl_i.run) begin
      cnt_q <= cnt_q + DCNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      r_q   <= {1'b0, el_i};
      d_q   <= {tot_i, {PINT_BITS{1'b0}}};
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (ctl_i.run) begin
      if (cnt_q == '0) begin
        // quotient of 256 or more: phase clips
        sat_q <= ge;
      end else begin
        r_q <= ge ? sub[TIME_BITS:0] : opnd;
        q_q <= {q_q[PW-2:0], ge};
      end
      if (cnt_q < DCNTW'(PINT_BITS)) begin
        d_q <= d_q >> 1;
      end
    end
  end

  assign sts_o.done = ctl_i.run && (cnt_q == DCNTW'(PW));
  assign sts_o.sat  = sat_q;
  assign sts_o.quo  = q_q;

endmodule

/* hw/rtl/terp_mul.sv */
// Digit-serial scaler: curve times range span, two multiplier bits per cycle.
module terp_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  terp_pkg::terp_unit_ctl_t   ctl_i,
  input  logic [terp_pkg::CW-1:0]    c_i,
  input  logic [terp_pkg::VW-1:0]    ad_i,
  output terp_pkg::terp_mul_sts_t    sts_o,
  output logic [terp_pkg::ACW-1:0]   acc_o
);
  import terp_pkg::*;

  logic [CPW-1:0]   c_q;
  logic [VW-1:0]    ad_q;
  logic [VW+1:0]    ad3_q;
  logic [ACW-1:0]   acc_q;
  logic             ovf_q;
  logic [MCNTW-1:0] cnt_q;
  logic [VW+1:0]    sel;
  logic             ovf_w;

  always_comb begin
    case (c_q[CPW-1 -: 2])
      2'd0:    sel = '0;
      2'd1:    sel = (VW+2)'(ad_q);
      2'd2:    sel = (VW+2)'(ad_q) << 1;
      default: sel = ad3_q;
    endcase
  end

  // after the integer digits the accumulator holds int(curve) * span
  assign ovf_w = (acc_q[ACW-1:OVF_EXP+1] != '0) ||
                 (acc_q[OVF_EXP] && (acc_q[OVF_EXP-1:0] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.load) begin
      cnt_q <= '0;
    end else if (ctl_i.run) begin
      cnt_q <= cnt_q + MCNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      c_q   <= CPW'(c_i) << (CPW - CW);
      ad_q  <= ad_i;
      ad3_q <= (VW+2)'(ad_i) + ((VW+2)'(ad_i) << 1);
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (ctl_i.run) begin
      acc_q <= (acc_q << 2) + ACW'(sel);
      c_q   <= c_q << 2;
      if (cnt_q == MCNTW'(CI_DIGITS)) begin
        ovf_q <= ovf_w;
      end
    end
  end

  assign sts_o.done = ctl_i.run && (cnt_q == MCNTW'(NDIG - 1));
  assign sts_o.ovf  = ovf_q;
  assign acc_o      = acc_q;

endmodule

/* hw/rtl/timed_easing_ramp_unit.sv */
// Timed easing ramp: time keeping, phase shaping, curve and output value.
//
// Channels: in_i takes requests (mode, now_us, duration_us); out_o returns one
// result (value, active, saturated) per request. Configuration registers
// (count mode, curve, range start, range end) are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; other indexes are ignored. The user must write
// them only while the unit is idle; the unit itself does not enforce this.
// The phase divider produces one quotient bit per cycle (PW+1 = 25 steps) and
// the scaler one two-bit digit per cycle (NDIG = 16 steps).
// One request is in flight at a time: in_i.ready is high only in idle, so the
// next request is taken only after the previous result is loaded into the
// output register. The result waits in that register; while the receiver
// stalls, the unit still accepts and works on the next request and only
// holds in its final state until the register frees up.
// Reset clears times, current value and configuration (range end to 1.0)
// and leaves no result pending.
module timed_easing_ramp_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [terp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [terp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  terp_in_if.sink                           in_i,
  terp_out_if.source                        out_o
);
  import terp_pkg::*;

  localparam logic [PW-1:0] PONE  = PW'(1) << PHASE_FRAC_BITS;
  localparam logic [PW-1:0] PTWO  = PONE << 1;
  localparam logic [PW-1:0] PHALF = PONE >> 1;
  localparam logic [PW-1:0] PMAX  = '1;
  localparam logic [VW-1:0] VMAX  = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN  = {1'b1, {(VW-1){1'b0}}};

  terp_state_e          state_q, state_d;
  terp_count_e          count_mode_q;
  terp_curve_e          curve_q;
  logic [VW-1:0]        range_start_q;
  logic [VW-1:0]        range_end_q;
  logic [TIME_BITS-1:0] start_q, end_q;
  logic [VW-1:0]        cur_q;

  terp_mode_e           mode_q;
  logic                 tot_zero_q;
  logic [PW-1:0]        op_q;
  logic                 lin_q;
  logic                 neg_q;
  logic [VW-1:0]        ad_q;
  logic                 sat_item_q;

  logic                 out_valid_q;
  logic [VW-1:0]        out_value_q;
  logic                 out_active_q;
  logic                 out_sat_q;

  logic                 accept;
  logic                 in_ready_w;
  logic                 out_load;
  logic                 curve_en;
  logic                 sum_en;
  logic                 hold_w;
  logic                 active_w;

  logic [TIME_BITS-1:0] now_t, dur_t, el_d, tot_d, start_d, end_d;

  terp_unit_ctl_t       div_ctl, mul_ctl;
  terp_div_sts_t        div_sts;
  terp_mul_sts_t        mul_sts;
  logic [ACW-1:0]       mul_acc;

  logic [PW-1:0]        phase_w, shaped_w, inv_w, op_d;
  logic                 lin_d;
  logic [VW:0]          diff_w, diff_neg_w;
  logic [2*PW-1:0]      sq_w;
  logic [CW-1:0]        c_w;
  logic [TW-1:0]        term_w;
  logic [RW-1:0]        rs_ext, term_ext, res_w;
  logic                 fits_w;

  function automatic logic curve_on(input terp_curve_e cv);
    logic on;
    on = (cv == CV_LINEAR) || (cv == CV_SQUARE) || (cv == CV_INV_SQUARE) ||
         (cv == CV_SPLIT);
    return on;
  endfunction

  function automatic logic [PW-1:0] shape(input terp_count_e cm, input logic [PW-1:0] p);
    logic [PW-1:0] w;
    logic [PW-1:0] s;
    w = p & (PTWO - PW'(1));
    case (cm)
      CM_NORMAL:      s = p;
      CM_CLAMP:       s = (p > PONE) ? PONE : p;
      CM_CLAMP_START: s = (p > PONE) ? '0 : p;
      CM_WRAP:        s = p & (PONE - PW'(1));
      CM_LOOP_ONCE:   s = (p > PTWO) ? '0 : ((p > PONE) ? p - PONE : p);
      CM_LOOP:        s = (w > PONE) ? w - PONE : w;
      default:        s = '0;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q  <= CM_NORMAL;
      curve_q       <= CV_NONE;
      range_start_q <= '0;
      range_end_q   <= VW'(32'h0001_0000);
    end else if (cfg_we_i) begin
      case (terp_reg_e'(cfg_idx_i))
        REG_COUNT_MODE:   count_mode_q  <= terp_count_e'(cfg_data_i[SEL_W-1:0]);
        REG_CURVE_SELECT: curve_q       <= terp_curve_e'(cfg_data_i[SEL_W-1:0]);
        REG_RANGE_START:  range_start_q <= cfg_data_i[VW-1:0];
        REG_RANGE_END:    range_end_q   <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign hold_w = (mode_q != MODE_TICK) || tot_zero_q || !curve_on(curve_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_DIV;
      S_DIV:   if (div_sts.done) state_d = hold_w ? S_FIN : S_CURVE;
      S_CURVE: state_d = S_SQR;
      S_SQR:   state_d = S_MUL;
      S_MUL:   if (mul_sts.done) state_d = S_SUM;
      S_SUM:   state_d = S_FIN;
      S_FIN:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_w   = (state_q == S_IDLE);
    div_ctl.load = in_ready_w && in_i.valid;
    div_ctl.run  = (state_q == S_DIV);
    mul_ctl.load = (state_q == S_SQR);
    mul_ctl.run  = (state_q == S_MUL);
    curve_en     = (state_q == S_CURVE);
    sum_en       = (state_q == S_SUM);
    out_load     = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  end

  assign accept      = div_ctl.load;
  assign in_i.ready  = in_ready_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- timing
  always_comb begin
    now_t   = TIME_BITS'(in_i.now_us);
    dur_t   = TIME_BITS'(in_i.duration_us);
    start_d = start_q;
    end_d   = end_q;
    el_d    = now_t - start_q;
    tot_d   = end_q - start_q;
    case (terp_mode_e'(in_i.mode))
      MODE_ACTIVATE: begin
        start_d = now_t;
        end_d   = now_t + dur_t;
        el_d    = '0;
        tot_d   = dur_t;
      end
      MODE_DEACTIVATE: begin
        start_d = '0;
        end_d   = '0;
        el_d    = now_t;
        tot_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (accept) begin
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= terp_mode_e'(in_i.mode);
      tot_zero_q <= (tot_d == '0);
    end
  end

  terp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .el_i   (el_d),
    .tot_i  (tot_d),
    .sts_o  (div_sts)
  );

  // ---------------------------------------------------------------- curve
  always_comb begin
    phase_w    = div_sts.sat ? PMAX : div_sts.quo;
    shaped_w   = shape(count_mode_q, phase_w);
    inv_w      = (shaped_w > PONE) ? shaped_w - PONE : PONE - shaped_w;
    lin_d      = 1'b0;
    case (curve_q)
      CV_LINEAR: begin
        op_d  = shaped_w;
        lin_d = 1'b1;
      end
      CV_SQUARE:     op_d = shaped_w;
      CV_INV_SQUARE: op_d = inv_w;
      default:       op_d = (shaped_w < PHALF) ? shaped_w : inv_w;
    endcase
    diff_w     = {range_end_q[VW-1], range_end_q} - {range_start_q[VW-1], range_start_q};
    diff_neg_w = -diff_w;
  end

  always_ff @(posedge clk_i) begin
    if (curve_en) begin
      op_q  <= op_d;
      lin_q <= lin_d;
      neg_q <= diff_w[VW];
      ad_q  <= diff_w[VW] ? diff_neg_w[VW-1:0] : diff_w[VW-1:0];
    end
  end

  assign sq_w = op_q * op_q;
  assign c_w  = lin_q ? CW'(op_q) : sq_w[2*PW-1:PHASE_FRAC_BITS];

  terp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .c_i    (c_w),
    .ad_i   (ad_q),
    .sts_o  (mul_sts),
    .acc_o  (mul_acc)
  );

  // ---------------------------------------------------------------- sum
  always_comb begin
    term_w   = mul_acc[ACW-1:FPAD];
    rs_ext   = {{(RW-VW){range_start_q[VW-1]}}, range_start_q};
    term_ext = {2'b00, term_w};
    res_w    = neg_q ? rs_ext - term_ext : rs_ext + term_ext;
    fits_w   = (res_w[RW-1:VW-1] == '0) || (res_w[RW-1:VW-1] == '1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (sum_en) begin
      if (mul_sts.ovf) begin
        cur_q <= neg_q ? VMIN : VMAX;
      end else if (!fits_w) begin
        cur_q <= res_w[RW-1] ? VMIN : VMAX;
      end else begin
        cur_q <= res_w[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      sat_item_q <= div_sts.sat || mul_sts.ovf || !fits_w;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    case (count_mode_q)
      CM_NORMAL, CM_CLAMP, CM_CLAMP_START:
        active_w = !tot_zero_q && !div_sts.sat &&
                   (div_sts.quo[PW-1:PHASE_FRAC_BITS] == '0);
      CM_LOOP_ONCE:
        active_w = !tot_zero_q && !div_sts.sat &&
                   (div_sts.quo[PW-1:PHASE_FRAC_BITS+1] == '0);
      CM_WRAP, CM_LOOP:
        active_w = !tot_zero_q;
      default:
        active_w = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= cur_q;
      out_active_q <= active_w;
      out_sat_q    <= !hold_w && sat_item_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value     = out_value_q;
  assign out_o.active    = out_active_q;
  assign out_o.saturated = out_sat_q;

endmodule

/* hw/rtl/terp_checker.sv */
// Port-level checks of the timed easing ramp, bound to the top level.
module terp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [terp_pkg::VW-1:0]   out_value_i,
  input logic                      out_active_i,
  input logic                      out_saturated_i
);
  import terp_pkg::*;

  // one request in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready while a request is in flight");

  // no result can appear in the cycle after a request enters
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result posted too early");

  // going idle means the result has been posted
  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> out_valid_i)
    else $error("unit went idle without a result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
      $stable(out_active_i) && $stable(out_saturated_i))
    else $error("stalled result changed");

endmodule

bind timed_easing_ramp_unit terp_checker u_terp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_value_i     (out_o.value),
  .out_active_i    (out_o.active),
  .out_saturated_i (out_o.saturated)
);

/* test/timed_easing_ramp_unit_tb.sv */
// Self-checking testbench of the timed easing ramp: a directed table, then random ramps.
module timed_easing_ramp_unit_tb;
  import terp_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 400_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS     = 200;
  localparam int unsigned SEG_ITEMS       = 38;

  localparam logic [63:0] PONE = 64'd1 << PHASE_FRAC_BITS;
  localparam logic [63:0] PMAX = (64'd1 << PW) - 64'd1;
  localparam longint      VMAX = 64'sd2147483647;
  localparam longint      VMIN = -64'sd2147483648;

  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [SEL_W-1:0]     CM_UNUSED   = 3'd6;
  localparam logic [SEL_W-1:0]     CV_UNUSED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 4'd9;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 active;
    logic                 saturated;
  } ramp_res_t;

  typedef struct packed {
    logic                  is_cfg;
    logic                  known;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [MODE_W-1:0]     mode;
    logic [NOW_W-1:0]      now_us;
    logic [DUR_W-1:0]      dur_us;
    ramp_res_t             want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  terp_in_if  in_ch ();
  terp_out_if out_ch ();

  timed_easing_ramp_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Ramp state and registers as the predictor sees them
  logic [SEL_W-1:0]     cur_count;
  logic [SEL_W-1:0]     cur_curve;
  logic signed [VW-1:0] cur_start;
  logic signed [VW-1:0] cur_end;
  logic signed [VW-1:0] ramp_value;
  logic [TIME_BITS-1:0] ramp_t0;
  logic [TIME_BITS-1:0] ramp_t1;

  ramp_res_t   expected_results [$];
  ramp_res_t   want_res;
  dir_row_t    dir_tab [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  bit          hold_off_req;
  logic [63:0] wall_us;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] sq_frac(input logic [63:0] d);
    return (d * d) >> PHASE_FRAC_BITS;
  endfunction

  // Advance the ramp by one request and return the result it must produce
  function automatic ramp_res_t ramp_step(input logic [MODE_W-1:0] md,
                                          input logic [NOW_W-1:0] now_v,
                                          input logic [DUR_W-1:0] dur_v);
    ramp_res_t   res;
    logic [63:0] el, tot, r, ph, sh, cv, inv, ad, ci, cf, term;
    logic        carry;
    longint      diff, sum;
    res.saturated = 1'b0;
    case (md)
      MODE_ACTIVATE: begin
        ramp_t0 = now_v;
        ramp_t1 = now_v + 64'(dur_v);
      end
      MODE_DEACTIVATE: begin
        ramp_t0 = '0;
        ramp_t1 = '0;
      end
      MODE_TICK: begin
        tot = ramp_t1 - ramp_t0;
        if (tot != 0 && cur_curve >= CV_LINEAR && cur_curve <= CV_SPLIT) begin
          el = now_v - ramp_t0;
          if (el / tot >= 256) begin
            ph = PMAX;
            res.saturated = 1'b1;
          end else begin
            ph = el / tot;
            r  = el % tot;
            // restoring division for the fraction, keep the bit shifted out
            for (int i = 0; i < PHASE_FRAC_BITS; i++) begin
              carry = r[63];
              r = r << 1;
              ph = ph << 1;
              if (carry || r >= tot) begin
                r = r - tot;
                ph[0] = 1'b1;
              end
            end
          end
          case (cur_count)
            CM_NORMAL:      sh = ph;
            CM_CLAMP:       sh = (ph > PONE) ? PONE : ph;
            CM_CLAMP_START: sh = (ph > PONE) ? 64'd0 : ph;
            CM_WRAP:        sh = ph & (PONE - 1);
            CM_LOOP_ONCE:   sh = (ph > 2 * PONE) ? 64'd0 : ((ph > PONE) ? ph - PONE : ph);
            CM_LOOP: begin
              sh = ph & (2 * PONE - 1);
              if (sh > PONE) sh = sh - PONE;
            end
            default:        sh = '0;
          endcase
          inv = (sh > PONE) ? sh - PONE : PONE - sh;
          case (cur_curve)
            CV_LINEAR:     cv = sh;
            CV_SQUARE:     cv = sq_frac(sh);
            CV_INV_SQUARE: cv = sq_frac(inv);
            default:       cv = (sh < PONE / 2) ? sq_frac(sh) : sq_frac(inv);
          endcase
          diff = longint'(cur_end) - longint'(cur_start);
          ad = (diff < 0) ? -diff : diff;
          ci = cv >> PHASE_FRAC_BITS;
          cf = cv & (PONE - 1);
          if (ci != 0 && ad > (64'd1 << 40) / ci) begin
            sum = (diff < 0) ? -64'sh1_0000_0000 : 64'sh1_0000_0000;
          end else begin
            term = ci * ad + ((cf * ad) >> PHASE_FRAC_BITS);
            sum = longint'(cur_start) + ((diff < 0) ? -longint'(term) : longint'(term));
          end
          if (sum > VMAX) begin
            sum = VMAX;
            res.saturated = 1'b1;
          end
          if (sum < VMIN) begin
            sum = VMIN;
            res.saturated = 1'b1;
          end
          ramp_value = sum[VW-1:0];
        end
      end
      default: ;
    endcase
    el = now_v - ramp_t0;
    tot = ramp_t1 - ramp_t0;
    case (cur_count)
      CM_NORMAL, CM_CLAMP, CM_CLAMP_START: res.active = el < tot;
      CM_LOOP_ONCE:                        res.active = el < tot || (el - tot) < tot;
      CM_WRAP, CM_LOOP:                    res.active = tot != 0;
      default:                             res.active = 1'b0;
    endcase
    res.value = ramp_value;
    return res;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic dir_row_t item_row(input logic [MODE_W-1:0] md,
                                        input logic [NOW_W-1:0] now_v,
                                        input logic [DUR_W-1:0] dur_v);
    dir_row_t row;
    row = '0;
    row.mode = md;
    row.now_us = now_v;
    row.dur_us = dur_v;
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [MODE_W-1:0] md,
                                         input logic [NOW_W-1:0] now_v,
                                         input logic [DUR_W-1:0] dur_v,
                                         input logic [VW-1:0] value,
                                         input logic act, input logic sat);
    dir_row_t row;
    row = item_row(md, now_v, dur_v);
    row.known = 1'b1;
    row.want.value = value;
    row.want.active = act;
    row.want.saturated = sat;
    return row;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return $urandom;
      default: return 32'($urandom_range(0, 524288)) - 32'd262144;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_COUNT_MODE:   cur_count = data[SEL_W-1:0];
      REG_CURVE_SELECT: cur_curve = data[SEL_W-1:0];
      REG_RANGE_START:  cur_start = data;
      REG_RANGE_END:    cur_end = data;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    if (expected_results.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic send_req(input logic [MODE_W-1:0] md, input logic [NOW_W-1:0] now_v,
                          input logic [DUR_W-1:0] dur_v);
    // close any register write burst
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.now_us <= now_v;
    in_ch.duration_us <= dur_v;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(ramp_step(md, now_v, dur_v));
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: result with no request pending: expected none, got %h",
                   $time, out_ch.value);
      end else begin
        want_res = expected_results.pop_front();
        if (out_ch.value !== want_res.value)
          report_mismatch("value", want_res.value, out_ch.value);
        if (out_ch.active !== want_res.active)
          report_mismatch("active", 32'(want_res.active), 32'(out_ch.active));
        if (out_ch.saturated !== want_res.saturated)
          report_mismatch("saturated", 32'(want_res.saturated), 32'(out_ch.saturated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned         idle_src [4] = '{0, 82, 0, 34};
    int unsigned         idle_snk [4] = '{0, 0, 82, 34};
    int unsigned         pick;
    int unsigned         sel_pick;
    logic [MODE_W-1:0]   md;
    logic [NOW_W-1:0]    now_v;
    logic [DUR_W-1:0]    dur_v;
    logic [63:0]         el;
    logic [63:0]         tot;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.now_us = '0;
    in_ch.duration_us = '0;
    cur_count = CM_NORMAL;
    cur_curve = CV_NONE;
    cur_start = '0;
    cur_end = Q_ONE;
    ramp_value = '0;
    ramp_t0 = '0;
    ramp_t1 = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_off_req = 1'b0;
    wall_us = 64'd5000;

    // Ramp from 1000 us lasting 1000 us; ticks at 1250, 1500, ... give phases 0.25, 0.5, ...
    dir_tab = '{
      known_row(MODE_TICK, 64'd1000, '0, '0, 1'b0, 1'b0),
      known_row(MODE_ACTIVATE, 64'd0, '0, '0, 1'b0, 1'b0),
      cfg_row(REG_CURVE_SELECT, CV_LINEAR),
      known_row(MODE_TICK, 64'd5, '0, '0, 1'b0, 1'b0),
      known_row(MODE_ACTIVATE, 64'd1000, 40'd1000, '0, 1'b1, 1'b0),
      item_row(MODE_TICK, 64'd1500, '0),
      item_row(MODE_TICK, 64'd2000, '0),
      item_row(MODE_TICK, 64'd301000, '0),
      item_row(MODE_TICK, 64'd10, '0),
      cfg_row(REG_RANGE_START, Q_MIN),
      cfg_row(REG_RANGE_END, Q_MAX),
      item_row(MODE_TICK, 64'd2000, '0),
      known_row(MODE_TICK, 64'd301000, '0, Q_MAX, 1'b0, 1'b1),
      cfg_row(REG_RANGE_START, Q_MAX),
      cfg_row(REG_RANGE_END, Q_MIN),
      known_row(MODE_TICK, 64'd301000, '0, Q_MIN, 1'b0, 1'b1),
      cfg_row(REG_RANGE_START, '0),
      cfg_row(REG_RANGE_END, Q_ONE),
      cfg_row(REG_COUNT_MODE, CM_CLAMP),
      item_row(MODE_TICK, 64'd2500, '0),
      cfg_row(REG_COUNT_MODE, CM_CLAMP_START),
      item_row(MODE_TICK, 64'd2000, '0),
      item_row(MODE_TICK, 64'd2500, '0),
      cfg_row(REG_COUNT_MODE, CM_WRAP),
      item_row(MODE_TICK, 64'd2500, '0),
      cfg_row(REG_COUNT_MODE, CM_LOOP_ONCE),
      item_row(MODE_TICK, 64'd2500, '0),
      item_row(MODE_TICK, 64'd3500, '0),
      cfg_row(REG_COUNT_MODE, CM_LOOP),
      item_row(MODE_TICK, 64'd4500, '0),
      cfg_row(REG_COUNT_MODE, CM_UNUSED),
      item_row(MODE_TICK, 64'd2500, '0),
      cfg_row(REG_COUNT_MODE, CM_NORMAL),
      cfg_row(REG_CURVE_SELECT, CV_SQUARE),
      item_row(MODE_TICK, 64'd1250, '0),
      cfg_row(REG_CURVE_SELECT, CV_INV_SQUARE),
      item_row(MODE_TICK, 64'd1250, '0),
      cfg_row(REG_CURVE_SELECT, CV_SPLIT),
      item_row(MODE_TICK, 64'd1250, '0),
      item_row(MODE_TICK, 64'd1500, '0),
      item_row(MODE_TICK, 64'd1750, '0),
      cfg_row(REG_CURVE_SELECT, CV_UNUSED),
      item_row(MODE_TICK, 64'd1900, '0),
      cfg_row(REG_UNUSED, 32'hFFFF_FFFF),
      cfg_row(REG_CURVE_SELECT, CV_LINEAR),
      item_row(MODE_UNUSED, 64'd1500, '0),
      item_row(MODE_DEACTIVATE, 64'd1500, '0),
      item_row(MODE_ACTIVATE, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF),
      item_row(MODE_TICK, 64'd100, '0),
      item_row(MODE_TICK, 64'h0000_007F_FFFF_FFFF, '0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
      end else begin
        send_req(dir_tab[i].mode, dir_tab[i].now_us, dir_tab[i].dur_us);
        if (dir_tab[i].known) expected_results[$] = dir_tab[i].want;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle_src[ph];
      snk_stall_pct = idle_snk[ph];
      for (int seg = 0; seg < 6; seg++) begin
        drain_results();
        write_reg(REG_COUNT_MODE, $urandom_range(0, 7));
        // favor the curves that compute over the holding codes
        sel_pick = $urandom_range(0, 11);
        write_reg(REG_CURVE_SELECT, (sel_pick < 8) ? sel_pick : sel_pick - 7);
        write_reg(REG_RANGE_START, rand_q16());
        write_reg(REG_RANGE_END, rand_q16());
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom);
        if (ph == 0 && seg == 1) hold_off_req = 1'b1;

        repeat (SEG_ITEMS) begin
          pick = $urandom_range(0, 99);
          md = MODE_TICK;
          dur_v = '0;
          now_v = wall_us;
          tot = ramp_t1 - ramp_t0;
          if (pick < 8) begin
            md = MODE_ACTIVATE;
            wall_us = wall_us + 64'($urandom_range(0, 1_000_000));
            now_v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : wall_us;
            case ($urandom_range(0, 9))
              0:       dur_v = '0;
              1:       dur_v = '1;
              2, 3:    dur_v = DUR_W'({$urandom, $urandom});
              default: dur_v = DUR_W'($urandom_range(1, 5000));
            endcase
          end else if (pick < 12) begin
            md = MODE_DEACTIVATE;
          end else if (pick < 14) begin
            md = MODE_UNUSED;
            now_v = {$urandom, $urandom};
          end else if (pick < 18) begin
            now_v = {$urandom, $urandom};
          end else begin
            // land around the running ramp: inside, on a boundary, far past or before it
            case ($urandom_range(0, 9))
              7:       el = tot * $urandom_range(0, 3);
              8:       el = tot * $urandom_range(256, 400) + 64'($urandom_range(0, 3));
              9:       el = -64'($urandom_range(1, 1000));
              default: el = (tot == 0) ? 64'($urandom_range(0, 5000))
                                       : {$urandom, $urandom} % (3 * tot + 1);
            endcase
            now_v = ramp_t0 + el;
          end
          send_req(md, now_v, dur_v);
        end
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
